FILE: src/mip_pkg.sv
// Shared constants, types and helpers for the mipmap 2x2 box-filter cascade.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mip_pkg;

  localparam int MAX_SIZE_LOG2_DEF = 10;
  localparam int CHANNEL_BITS_DEF  = 16;

  // Configuration register width and reset value.
  localparam int          CFG_W     = 4;
  localparam logic [3:0]  CFG_RESET = 4'd10;

  // Register word indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_WIDTH_LOG2  = 1'b0,
    REG_HEIGHT_LOG2 = 1'b1
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take the input texel, start at level 1
    logic step;     // execute the current level this cycle
    logic advance;  // move on to the next level after this step
  } mip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the current level completes a 2x2 block
    logic more;      // a further level exists below the current one
    logic out_busy;  // output register full and not being taken
  } mip_sts_t;

  // Exponents below one act as one, above the maximum as the maximum.
  function automatic logic [CFG_W-1:0] clamp_log2(input logic [CFG_W-1:0] v,
                                                  input int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(maxv)) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

endpackage

FILE: src/mip_ctrl.sv
// Controller state machine of the mipmap cascade: accepts a texel, then walks the
// levels one per cycle unless the output stalls. Uses mip_pkg's cmd/sts types.
`timescale 1ns / 1ps

module mip_ctrl
  import mip_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mip_sts_t sts_i,
  output mip_cmd_t cmd_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.step     = (state_q == ST_EXEC) && !(sts_i.emit && sts_i.out_busy);
  assign cmd_o.advance  = cmd_o.step && sts_i.emit && sts_i.more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd_o.step && !cmd_o.advance) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A level that completes no block ends the work on the current texel.
  a_noemit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && !sts_i.emit) |=> (state_q == ST_IDLE))
    else $error("level without result did not end the texel");

  // A stalled result keeps the controller on the same level.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !cmd_o.step) |=> (state_q == ST_EXEC))
    else $error("controller left a stalled level");

  // An accepted texel always starts execution in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC && !in_ready_o))
    else $error("accepted texel not executed");
`endif

endmodule

FILE: src/mip_datapath.sv
// Datapath of the mipmap cascade: per-level counters and holds, the pair-sum
// line memory, the box-filter adders and the output register. Uses mip_pkg.
`timescale 1ns / 1ps

module mip_datapath
  import mip_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int LVL_W         = $clog2(MAX_SIZE_LOG2 + 1),
  parameter int COL_W         = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1
)
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CFG_W-1:0]        width_log2_i,
  input  logic [CFG_W-1:0]        height_log2_i,
  input  logic                    clear_i,
  input  mip_cmd_t                cmd_i,
  output mip_sts_t                sts_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LVL_W-1:0]        level_o,
  output logic [COL_W-1:0]        column_o,
  output logic [COL_W-1:0]        row_o,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic                    last_o
);

  localparam int M     = MAX_SIZE_LOG2;
  localparam int C     = CHANNEL_BITS;
  localparam int IDX_W = (M > 1) ? $clog2(M) : 1;
  localparam int DEPTH = (1 << M) - 1;
  localparam int PS_W  = C + 1;

  // Per-level position counters, holds and the line memory of pair sums.
  logic [M-1:0]    col_q [M];
  logic [M-1:0]    row_q [M];
  logic [3*C-1:0]  hold_q [M];
  logic [3*PS_W-1:0] line_mem [DEPTH];
  logic [3*PS_W-1:0] rd_q;

  logic [LVL_W-1:0] lvl_q;
  logic [3*C-1:0]   val_q;
  logic [M-1:0]     cur_col_q;
  logic [M-1:0]     cur_row_q;
  logic [M-1:0]     addr_q;

  logic             out_valid_q;
  logic [LVL_W-1:0] level_q;
  logic [COL_W-1:0] column_q;
  logic [COL_W-1:0] row_out_q;
  logic [3*C-1:0]   rgb_q;
  logic             last_q;

  logic [CFG_W-1:0] wl, hl, nlev;
  logic [LVL_W-1:0] nxt_lvl;
  logic [IDX_W-1:0] nxt_idx, cur_idx;
  logic             nxt_ok;
  logic [M-1:0]     nxt_col, nxt_row, base, rd_addr;
  logic             rd_en, wr_en, emit, more, last;
  logic [3*C-1:0]   hold_cur;
  logic [3*PS_W-1:0] pair;
  logic [3*C-1:0]   avg;
  logic [4:0]       sh_w, sh_h;
  logic [M:0]       col_inc, row_inc, ws, hs;

  assign wl   = clamp_log2(width_log2_i, M);
  assign hl   = clamp_log2(height_log2_i, M);
  assign nlev = (wl < hl) ? wl : hl;

  // Level whose line entry is fetched: level 1 on accept, else the next one.
  assign nxt_lvl = cmd_i.accept ? '0 : lvl_q + LVL_W'(1);
  assign nxt_ok  = nxt_lvl < LVL_W'(M);
  assign nxt_idx = nxt_ok ? nxt_lvl[IDX_W-1:0] : '0;
  assign cur_idx = lvl_q[IDX_W-1:0];
  assign nxt_col = col_q[nxt_idx];
  assign nxt_row = row_q[nxt_idx];

  // Each source level owns the region starting at 2^M - 2^(M-s).
  assign base    = {M{1'b1}} << (LVL_W'(M) - nxt_lvl);
  assign rd_addr = base + (nxt_col >> 1);
  assign rd_en   = cmd_i.accept | cmd_i.advance;

  assign more = (5'(lvl_q) + 5'd1) < 5'(nlev);
  assign emit = cur_col_q[0] & cur_row_q[0];
  // The next level emits only if both its counters are odd.
  assign last = !(more && nxt_col[0] && nxt_row[0]);

  assign hold_cur = hold_q[cur_idx];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [C+1:0] tot;
      pair[ch*PS_W +: PS_W] = PS_W'(hold_cur[ch*C +: C]) + PS_W'(val_q[ch*C +: C]);
      tot = (C+2)'(rd_q[ch*PS_W +: PS_W]) + (C+2)'(hold_cur[ch*C +: C])
          + (C+2)'(val_q[ch*C +: C]);
      avg[ch*C +: C] = tot[C+1:2];
    end
  end

  assign wr_en = cmd_i.step && cur_col_q[0] && !cur_row_q[0];

  assign sh_w    = 5'(wl) - 5'(lvl_q);
  assign sh_h    = 5'(hl) - 5'(lvl_q);
  assign ws      = (M+1)'(1) << sh_w;
  assign hs      = (M+1)'(1) << sh_h;
  assign col_inc = (M+1)'(cur_col_q) + (M+1)'(1);
  assign row_inc = (M+1)'(cur_row_q) + (M+1)'(1);

  assign sts_o.emit     = emit;
  assign sts_o.more     = more;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // Line memory: at most one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[addr_q] <= pair;
    end
    if (rd_en) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  // Counters of every level, cleared at reset and on a register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < M; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < M; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (cmd_i.step) begin
      if (col_inc >= ws) begin
        col_q[cur_idx] <= '0;
        row_q[cur_idx] <= (row_inc >= hs) ? '0 : M'(row_inc);
      end else begin
        col_q[cur_idx] <= M'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        lvl_q <= '0;
      end else if (cmd_i.advance) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cur_col_q <= nxt_col;
      cur_row_q <= nxt_row;
      addr_q    <= rd_addr;
    end
    if (cmd_i.accept) begin
      val_q <= {blue_i, green_i, red_i};
    end else if (cmd_i.step && emit) begin
      val_q <= avg;
    end
    if (cmd_i.step && !cur_col_q[0]) begin
      hold_q[cur_idx] <= val_q;
    end
    if (cmd_i.step && emit) begin
      level_q   <= lvl_q + LVL_W'(1);
      column_q  <= COL_W'(cur_col_q >> 1);
      row_out_q <= COL_W'(cur_row_q >> 1);
      rgb_q     <= avg;
      last_q    <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign column_o    = column_q;
  assign row_o       = row_out_q;
  assign red_o       = rgb_q[0 +: C];
  assign green_o     = rgb_q[C +: C];
  assign blue_o      = rgb_q[2*C +: C];
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // The level being executed always lies within the image's level count.
  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (5'(lvl_q) < 5'(nlev)))
    else $error("executing a level beyond the last one");

  // Moving to the next level happens only after a completed block.
  a_adv_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (emit && more && cmd_i.step))
    else $error("level advanced without a result");
`endif

endmodule

FILE: src/mipmap_box_downsample_cascade_top.sv
// Top level of the mipmap 2x2 box-filter cascade: configuration registers,
// stream packing and the controller/datapath pair. Uses mip_pkg, mip_ctrl, mip_datapath.
`timescale 1ns / 1ps
//
// Usage
//   Base texels enter in raster order on the slave stream (s_tdata_i holds red,
//   green and blue). For every texel the block works down the mip levels, one
//   level per cycle unless the output stalls, until a level completes no 2x2 block
//   or the last level is done. Each completed block leaves as one transfer on
//   the master stream, level 1 first; m_tlast_o marks the last result caused
//   by a texel. The APB port sets the base width and height exponents; a write
//   also restarts the image at its first texel.
// Flow
//   A texel is taken in together with the line-memory read of its level-1 pair
//   sum; then each level in turn does the add, the write-back and the fetch of
//   the next level's pair sum through the single registered line-memory read.
//   No new texel is taken until the walk of the current one has ended. When
//   the receiver stalls, the output register holds its result and the walk
//   pauses on the next level that needs to emit.
// Reset
//   Reset clears all position counters and sets both exponents to ten. The line
//   memory and holds are not cleared: the raster order writes them before use.

module mipmap_box_downsample_cascade_top
  import mip_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int LVL_W         = $clog2(MAX_SIZE_LOG2 + 1),
  parameter int COL_W         = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1,
  parameter int IN_W          = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  parameter int OUT_W         = ((LVL_W + 2 * COL_W + 3 * CHANNEL_BITS + 7) / 8) * 8
)
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Slave stream
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [IN_W-1:0]  s_tdata_i,   // red_in, green_in, blue_in (low to high)
  // Master stream
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o,   // level, column, row, red_out, green_out, blue_out
  output logic             m_tlast_o,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int C = CHANNEL_BITS;

  logic [CFG_W-1:0] width_log2_q;
  logic [CFG_W-1:0] height_log2_q;
  logic             cfg_wr;
  reg_idx_e         reg_sel;

  mip_cmd_t cmd;
  mip_sts_t sts;

  logic [LVL_W-1:0] level;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] row;
  logic [C-1:0]     red_out, green_out, blue_out;

  // Registers are word aligned: bit 2 of the address selects one of the two.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= CFG_RESET;
      height_log2_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH_LOG2:  width_log2_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT_LOG2: height_log2_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH_LOG2:  prdata = 32'(width_log2_q);
      REG_HEIGHT_LOG2: prdata = 32'(height_log2_q);
      default:         prdata = '0;
    endcase
  end

  mip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mip_datapath #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .CHANNEL_BITS  (CHANNEL_BITS),
    .LVL_W         (LVL_W),
    .COL_W         (COL_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_log2_i  (width_log2_q),
    .height_log2_i (height_log2_q),
    .clear_i       (cfg_wr),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .red_i         (s_tdata_i[0 +: C]),
    .green_i       (s_tdata_i[C +: C]),
    .blue_i        (s_tdata_i[2*C +: C]),
    .out_valid_o   (m_tvalid_o),
    .out_ready_i   (m_tready_i),
    .level_o       (level),
    .column_o      (column),
    .row_o         (row),
    .red_o         (red_out),
    .green_o       (green_out),
    .blue_o        (blue_out),
    .last_o        (m_tlast_o)
  );

  // Fields packed from the lowest bit up, zero filled to whole bytes.
  assign m_tdata_o = OUT_W'({blue_out, green_out, red_out, row, column, level});

endmodule

FILE: bench/mip_cascade_checker.sv
// Stream and register watcher for the mipmap 2x2 box-filter cascade: predicts
// every averaged texel and compares it with what the block sends. Uses mip_pkg.
`timescale 1ns / 1ps

module mip_cascade_checker
  import mip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,   // red_in, green_in, blue_in (low to high)
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,   // level, column, row, red_out, green_out, blue_out
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam int MAXL       = MAX_SIZE_LOG2_DEF;
  localparam int LINE_DEPTH = (1 << MAXL) - 1;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } texel_t;

  typedef struct packed {
    logic [17:0] blue;
    logic [17:0] green;
    logic [17:0] red;
  } pair_sum_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [8:0]  column;
    logic [8:0]  row;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } mip_texel_t;

  pair_sum_t  pair_line [LINE_DEPTH];
  texel_t     left_hold [MAXL];
  int         col_cnt [MAXL];
  int         row_cnt [MAXL];
  logic [3:0] width_cfg;
  logic [3:0] height_cfg;
  mip_texel_t mip_texel_q [$];
  int         mismatches = 0;

  function automatic int clamp_exp(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (int'(v) > MAXL) return MAXL;
    return int'(v);
  endfunction

  function automatic string describe(mip_texel_t t);
    return $sformatf("level %0d col %0d row %0d rgb %h %h %h last %b",
                     t.level, t.column, t.row, t.red, t.green, t.blue, t.last);
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void clear_positions();
    for (int s = 0; s < MAXL; s++) begin
      col_cnt[s] = 0;
      row_cnt[s] = 0;
    end
  endfunction

  // Walks the texel down the levels; each level either holds the left texel,
  // stores a pair sum of an even row, or completes a block and passes the
  // average on to the next level.
  function automatic void predict_texels(texel_t t);
    int          wl, hl, nlev, s, ws, hs, idx, c, r, n;
    logic [17:0] sr, sg, sb;
    texel_t      v;
    mip_texel_t  batch [MAXL];
    bit          emit;
    wl = clamp_exp(width_cfg);
    hl = clamp_exp(height_cfg);
    nlev = (wl < hl) ? wl : hl;
    v = t;
    n = 0;
    for (int k = 1; k <= nlev; k++) begin
      s = k - 1;
      ws = 1 << (wl - s);
      hs = 1 << (hl - s);
      c = col_cnt[s];
      r = row_cnt[s];
      idx = (1 << MAXL) - (1 << (MAXL - s)) + (c >> 1);
      if (idx >= LINE_DEPTH) idx = 0;
      emit = 1'b0;
      if (c % 2 == 0) begin
        left_hold[s] = v;
      end else if (r % 2 == 0) begin
        pair_line[idx].red   = {2'b00, left_hold[s].red}   + {2'b00, v.red};
        pair_line[idx].green = {2'b00, left_hold[s].green} + {2'b00, v.green};
        pair_line[idx].blue  = {2'b00, left_hold[s].blue}  + {2'b00, v.blue};
      end else begin
        sr = pair_line[idx].red   + {2'b00, left_hold[s].red}   + {2'b00, v.red};
        sg = pair_line[idx].green + {2'b00, left_hold[s].green} + {2'b00, v.green};
        sb = pair_line[idx].blue  + {2'b00, left_hold[s].blue}  + {2'b00, v.blue};
        v.red   = sr[17:2];
        v.green = sg[17:2];
        v.blue  = sb[17:2];
        emit = 1'b1;
      end
      col_cnt[s] = c + 1;
      if (col_cnt[s] >= ws) begin
        col_cnt[s] = 0;
        row_cnt[s] = r + 1;
        if (row_cnt[s] >= hs) row_cnt[s] = 0;
      end
      if (!emit) break;
      batch[n].level  = 4'(k);
      batch[n].column = 9'(c >> 1);
      batch[n].row    = 9'(r >> 1);
      batch[n].red    = v.red;
      batch[n].green  = v.green;
      batch[n].blue   = v.blue;
      batch[n].last   = 1'b0;
      n++;
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) mip_texel_q = {mip_texel_q, batch[i]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mip_texel_t got;
    mip_texel_t want;
    logic [3:0] reg_val;
    if (!rst_ni) begin
      clear_positions();
      width_cfg = CFG_RESET;
      height_cfg = CFG_RESET;
      mip_texel_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.level  = m_tdata_i[3:0];
        got.column = m_tdata_i[12:4];
        got.row    = m_tdata_i[21:13];
        got.red    = m_tdata_i[37:22];
        got.green  = m_tdata_i[53:38];
        got.blue   = m_tdata_i[69:54];
        got.last   = m_tlast_i;
        if (mip_texel_q.size() == 0) begin
          flag({"unexpected texel: ", describe(got)});
        end else begin
          want = mip_texel_q.pop_front();
          if (got !== want) begin
            flag({"texel mismatch: expected ", describe(want), ", got ", describe(got)});
          end
        end
      end
      if (s_tvalid_i && s_tready_i) predict_texels(texel_t'(s_tdata_i));
      if (psel_i && penable_i && pready_i && paddr_i[1:0] == 2'b00) begin
        reg_val = (reg_idx_e'(paddr_i[2]) == REG_WIDTH_LOG2) ? width_cfg : height_cfg;
        if (pwrite_i) begin
          if (reg_idx_e'(paddr_i[2]) == REG_WIDTH_LOG2) begin
            width_cfg = pwdata_i[3:0];
          end else begin
            height_cfg = pwdata_i[3:0];
          end
          clear_positions();
        end else if (prdata_i[3:0] !== reg_val) begin
          flag($sformatf("register read at %0d: expected %h, got %h",
                         paddr_i, reg_val, prdata_i[3:0]));
        end
      end
    end
    outstanding_o <= mip_texel_q.size();
    mismatches_o <= mismatches;
  end

endmodule

FILE: bench/tb_top.sv
// Top of the mipmap cascade testbench: clock, reset, stimulus and the verdict.
// Uses mip_pkg, mipmap_box_downsample_cascade_top and mip_cascade_checker.
`timescale 1ns / 1ps

module tb_top;
  import mip_pkg::*;

  // Cycles allowed after the last expected texel for a texel that is still
  // walking levels without emitting: its fetch, then each of its levels.
  localparam int DRAIN_CYCLES    = 16;
  // Length of the one long receiver hold-off, long enough to fill the block.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 280;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  // Idling is switched off for one long phase; the hold-off request is picked
  // up by the receiver process, which counts out the stall itself.
  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;
  logic [3:0]  cur_w = CFG_RESET;
  logic [3:0]  cur_h = CFG_RESET;

  always #1 clk = ~clk;

  mipmap_box_downsample_cascade_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mip_cascade_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // The effective exponent, as the block clamps it; used only to size images.
  function automatic int eff_exp(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd10) return 10;
    return int'(v);
  endfunction

  // Random texel, with each channel now and then forced to zero or full scale.
  function automatic logic [47:0] rand_texel();
    logic [47:0] d;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 9))
        0: d[ch*16 +: 16] = 16'h0000;
        1: d[ch*16 +: 16] = 16'hFFFF;
        default: d[ch*16 +: 16] = 16'($urandom);
      endcase
    end
    return d;
  endfunction

  // Offers one texel, after an optional random gap, and returns at the edge
  // on which the transfer takes place. Nothing is assigned on that edge, so
  // the next call or the drain may drive tvalid there.
  task automatic send_texel(input logic [47:0] d);
    while (gaps_on && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted texel has come out, then
  // lets the block finish any walk that emits nothing.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: a setup phase, then the access phase until pready.
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the exponents (the width may be left alone, which still restarts
  // the image through the height write) and reads both back. The upper data
  // bits are random; only the low four are stored.
  task automatic configure(input logic [3:0] w, input logic [3:0] h, input bit keep_width);
    if (!keep_width) begin
      apb_access(1'b1, REG_WIDTH_LOG2, {28'($urandom), w});
      cur_w = w;
    end
    apb_access(1'b1, REG_HEIGHT_LOG2, {28'($urandom), h});
    cur_h = h;
    apb_access(1'b0, REG_WIDTH_LOG2, '0);
    apb_access(1'b0, REG_HEIGHT_LOG2, '0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_tready <= !gaps_on || ($urandom_range(0, 99) >= 27);
    end
  end

  // Generous upper bound on the run; a correct run ends far sooner.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int         items;
    int         phase;
    int         count;
    int         span;
    logic [3:0] w;
    logic [3:0] h;
    bit         keep;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset size of 1024 by 1024 the first row completes no block,
    // so these texels only fill holds and line entries.
    send_texel(48'h0);
    send_texel(48'hFFFF_FFFF_FFFF);
    drain();

    // Smallest image, 2 by 2: full scale stays full scale, zero stays zero,
    // and the sum is truncated rather than rounded.
    configure(4'd1, 4'd1, 1'b0);
    repeat (4) send_texel(48'hFFFF_FFFF_FFFF);
    repeat (4) send_texel(48'h0);
    send_texel({16'hFFFF, 16'd3, 16'd1});
    send_texel({16'hFFFF, 16'd3, 16'd1});
    send_texel({16'hFFFF, 16'd3, 16'd1});
    send_texel({16'hFFFE, 16'd3, 16'd0});
    drain();

    // An exponent of zero acts as one and one above the maximum as the
    // maximum: a 2-wide, 1024-high image emits on every second row.
    configure(4'd0, 4'd15, 1'b0);
    repeat (4) send_texel(rand_texel());
    drain();

    // The widest image with the least height: the first row emits nothing.
    configure(4'd15, 4'd1, 1'b0);
    repeat (4) send_texel(rand_texel());
    drain();

    // Random phases. The first is an 8 by 8 image during which the receiver
    // holds off long enough to back the block up into its input; the second
    // is a 16 by 8 image with no idling on either side, reaching level 3.
    // Later phases are mostly whole small images (sometimes two in a row, so
    // the counters wrap) with random content, some cut short by the next
    // register write, and some partial runs at extreme or clamped sizes.
    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      keep = 1'b0;
      case (phase)
        0: begin
          w = 4'd3;
          h = 4'd3;
        end
        1: begin
          w = 4'd4;
          h = 4'd3;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: begin
              w = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(11, 15));
              h = 4'($urandom_range(1, 3));
            end
            1: begin
              w = 4'($urandom_range(1, 3));
              h = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(11, 15));
            end
            2: begin
              w = 4'($urandom_range(1, 2));
              h = 4'd10;
            end
            3: begin
              w = 4'd10;
              h = 4'($urandom_range(1, 10));
            end
            default: begin
              w = 4'($urandom_range(1, 3));
              h = 4'($urandom_range(1, 3));
              keep = ($urandom_range(0, 4) == 0);
            end
          endcase
        end
      endcase
      configure(w, h, keep);

      span = eff_exp(cur_w) + eff_exp(cur_h);
      if (phase == 1 || span <= 6) begin
        count = (1 << span) * ((phase < 2) ? 1 : $urandom_range(1, 2));
        if (phase >= 2 && $urandom_range(0, 4) == 0) count = $urandom_range(1, count - 1);
      end else begin
        count = $urandom_range(4, 40);
      end

      gaps_on = (phase != 1);
      if (phase == 0) hold_off_req = 1'b1;
      for (int i = 0; i < count; i++) begin
        send_texel(rand_texel());
        items++;
      end
      drain();
      gaps_on = 1'b1;
      phase++;
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mip_pkg.sv
src/mip_ctrl.sv
src/mip_datapath.sv
src/mipmap_box_downsample_cascade_top.sv
bench/mip_cascade_checker.sv
bench/tb_top.sv
